// File: src/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic               is_full;
    logic               accepted;
  } deq_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } deq_cmd_t;

  // base + offset, modulo DEPTH; sum is always below 2*DEPTH
  function automatic logic [IDX_W-1:0] slot_wrap(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = (s >= (CNT_W+1)'(DEPTH)) ? s - (CNT_W+1)'(DEPTH) : s;
    return t[IDX_W-1:0];
  endfunction

endpackage

// File: src/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: latch, execute, read back, report.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output deq_pkg::deq_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_RESP} state_t;

  state_t state;

  always_comb begin
    cmd.load = start && !busy;
    cmd.exec = (state == S_EXEC);
    cmd.read = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_RESP;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_RESP: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: src/deq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Circular word store, front index and occupancy, result registers.
// ----------------------------------------------------------------------------
module deq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::deq_cmd_t cmd,
  input  deq_pkg::deq_in_t  item,
  output deq_pkg::deq_out_t result
);

  logic [31:0]                  mem [deq_pkg::DEPTH];
  logic [deq_pkg::IDX_W-1:0]    front_idx;
  logic [deq_pkg::CNT_W-1:0]    occ;
  logic [2:0]                   act;
  logic signed [31:0]           val;
  logic                         ok;
  logic [31:0]                  rd_front;
  logic [31:0]                  rd_back;

  logic [deq_pkg::IDX_W-1:0]    front_idx_next;
  logic [deq_pkg::CNT_W-1:0]    occ_next;
  logic                         ok_next;
  logic                         wr_en;
  logic [deq_pkg::IDX_W-1:0]    wr_addr;
  logic [deq_pkg::IDX_W-1:0]    front_dec;
  logic [deq_pkg::IDX_W-1:0]    back_addr;
  logic                         is_empty;
  logic                         is_full;
  logic [deq_pkg::CNT_W-1:0]    occ_m1;

  assign is_empty = (occ == '0);
  assign is_full  = (occ == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign occ_m1   = is_empty ? '0 : occ - 1'b1;

  assign front_dec = (front_idx == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
                                       : front_idx - 1'b1;
  assign back_addr = deq_pkg::slot_wrap((deq_pkg::CNT_W+1)'(front_idx)
                                        + (deq_pkg::CNT_W+1)'(occ_m1));

  always_comb begin
    front_idx_next = front_idx;
    occ_next       = occ;
    ok_next        = 1'b1;
    wr_en          = 1'b0;
    wr_addr        = front_dec;
    unique case (act)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = front_dec;
          front_idx_next = front_dec;
          occ_next       = occ + 1'b1;
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = deq_pkg::slot_wrap((deq_pkg::CNT_W+1)'(front_idx)
                                        + (deq_pkg::CNT_W+1)'(occ));
          occ_next = occ + 1'b1;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          front_idx_next = deq_pkg::slot_wrap((deq_pkg::CNT_W+1)'(front_idx) + 1'b1);
          occ_next       = occ - 1'b1;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          occ_next = occ - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx <= '0;
      occ       <= '0;
    end else if (cmd.exec) begin
      front_idx <= front_idx_next;
      occ       <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= item.action;
      val <= item.push_value;
    end
    if (cmd.exec) begin
      ok <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front <= mem[front_idx];
      rd_back  <= mem[back_addr];
    end
  end

  always_comb begin
    result.front_value = is_empty ? deq_pkg::EMPTY_WORD : rd_front;
    result.back_value  = is_empty ? deq_pkg::EMPTY_WORD : rd_back;
    result.is_empty    = is_empty;
    result.is_full     = is_full;
    result.accepted    = ok;
  end

endmodule

// File: src/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
//  channel   ports                 transfer
//  item      start, busy, cmd      at a rising edge with start high, busy low
//  result    done, result          done high for one cycle, taken at its end
//
//  An item passes through execute (store write, pointer update), registered
//  store read of front and back, then the result cycle with done high.
//  busy is low in the result cycle, so a new item may follow right away.
//  Synchronous active-high reset clears the pointers and the occupancy.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  cmd,
  output logic              done,
  output deq_pkg::deq_out_t result
);

  deq_pkg::deq_cmd_t ctl;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (ctl)
  );

  deq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ctl),
    .item   (cmd),
    .result (result)
  );

endmodule
